// ===== design/cpd_pkg.sv =====
// Shared types and constants for the command payload deframer.
// Used by cpd_front, cpd_queue, cpd_back and command_payload_deframer.
package cpd_pkg;

  // Byte counter saturates here (17-bit counter)
  localparam logic [16:0] BYTE_COUNT_MAX = 17'h1FFFF;

  // Decoupling queue between parser and output sequencer
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Parser phase
  typedef enum logic [1:0] {
    PH_HEADER   = 2'd0,
    PH_ARG_HDR  = 2'd1,
    PH_ARG_DATA = 2'd2,
    PH_TAIL     = 2'd3
  } phase_t;

  // Packet verdict codes
  typedef enum logic [2:0] {
    V_OK       = 3'd0,
    V_LENGTH   = 3'd1,
    V_ZERO_CMD = 3'd2,
    V_SEQUENCE = 3'd3,
    V_TOO_FEW  = 3'd4,
    V_TRUNC    = 3'd5
  } verdict_t;

  // Result kinds on tuser
  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Work for one accepted byte: an optional data result and an optional verdict
  typedef struct packed {
    logic       has_data;
    logic       has_verdict;
    logic [7:0] command;
    logic [7:0] arg_total;
    logic [7:0] arg_number;
    logic [7:0] arg_kind;
    logic [7:0] payload;
    logic       arg_end;
    logic [7:0] args_parsed;
    verdict_t   verdict;
  } cpd_entry_t;

endpackage

// ===== design/cpd_front.sv =====
// Front end: accepts packet bytes, parses headers and classifies each byte.
// Produces one queue entry per byte that causes a result. Depends on cpd_pkg.
module cpd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_data,
  input  logic              in_last,
  input  logic              room,
  output logic              push,
  output cpd_pkg::cpd_entry_t entry
);
  import cpd_pkg::*;

  phase_t      phase, phase_next;
  logic [1:0]  field_pos, field_pos_next;
  logic [16:0] byte_count, byte_count_next;
  logic [15:0] declared_length, declared_length_next;
  logic [7:0]  command_reg, command_reg_next;
  logic [7:0]  arg_count, arg_count_next;
  logic [7:0]  args_seen, args_seen_next;
  logic [7:0]  cur_type, cur_type_next;
  logic [15:0] remaining, remaining_next;
  verdict_t    error_code, error_code_next;

  logic        fire;
  logic [7:0]  seen_inc;
  logic [15:0] remaining_dec;
  logic        data_item;
  verdict_t    judged;

  assign in_ready = room;
  assign fire     = in_valid && room;
  assign seen_inc = args_seen + 8'd1;
  assign remaining_dec = remaining - 16'd1;

  // Parser next state
  always_comb begin
    phase_next           = phase;
    field_pos_next       = field_pos;
    declared_length_next = declared_length;
    command_reg_next     = command_reg;
    arg_count_next       = arg_count;
    args_seen_next       = args_seen;
    cur_type_next        = cur_type;
    remaining_next       = remaining;
    error_code_next      = error_code;
    data_item            = 1'b0;
    byte_count_next = (byte_count == BYTE_COUNT_MAX) ? byte_count : byte_count + 17'd1;

    case (phase)
      PH_HEADER: begin
        case (field_pos)
          2'd0: command_reg_next = in_data;
          2'd1: arg_count_next = in_data;
          2'd2: declared_length_next = {in_data, 8'd0};
          default: begin
            declared_length_next = {declared_length[15:8], in_data};
            phase_next = (command_reg != 8'd0 && arg_count != 8'd0) ? PH_ARG_HDR : PH_TAIL;
          end
        endcase
        field_pos_next = field_pos + 2'd1;
      end
      PH_ARG_HDR: begin
        case (field_pos)
          2'd0: begin
            if (in_data != seen_inc) begin
              error_code_next = V_SEQUENCE;
              phase_next      = PH_TAIL;
            end else begin
              field_pos_next = 2'd1;
            end
          end
          2'd1: begin
            cur_type_next  = in_data;
            field_pos_next = 2'd2;
          end
          2'd2: begin
            remaining_next = {in_data, 8'd0};
            field_pos_next = 2'd3;
          end
          default: begin
            remaining_next = {remaining[15:8], in_data};
            field_pos_next = 2'd0;
            if ({remaining[15:8], in_data} == 16'd0) begin
              args_seen_next = seen_inc;
              phase_next     = (seen_inc == arg_count) ? PH_TAIL : PH_ARG_HDR;
            end else begin
              phase_next = PH_ARG_DATA;
            end
          end
        endcase
      end
      PH_ARG_DATA: begin
        data_item      = 1'b1;
        remaining_next = remaining_dec;
        if (remaining_dec == 16'd0) begin
          args_seen_next = seen_inc;
          phase_next     = (seen_inc == arg_count) ? PH_TAIL : PH_ARG_HDR;
        end
      end
      default: ;
    endcase
  end

  // Verdict on the updated state, in priority order
  always_comb begin
    if (phase_next == PH_HEADER)
      judged = V_LENGTH;
    else if (byte_count_next != {1'b0, declared_length_next})
      judged = V_LENGTH;
    else if (command_reg_next == 8'd0)
      judged = V_ZERO_CMD;
    else if (error_code_next != V_OK)
      judged = error_code_next;
    else if (arg_count_next == 8'd0)
      judged = V_OK;
    else if (phase_next == PH_ARG_DATA || (phase_next == PH_ARG_HDR && field_pos_next != 2'd0))
      judged = V_TRUNC;
    else if (args_seen_next < arg_count_next)
      judged = V_TOO_FEW;
    else
      judged = V_OK;
  end

  // Queue entry for this byte
  always_comb begin
    entry.has_data    = data_item;
    entry.has_verdict = in_last;
    entry.command     = command_reg_next;
    entry.arg_total   = arg_count_next;
    entry.arg_number  = seen_inc;
    entry.arg_kind    = cur_type;
    entry.payload     = in_data;
    entry.arg_end     = (remaining_dec == 16'd0);
    entry.args_parsed = args_seen_next;
    entry.verdict     = judged;
  end

  assign push = fire && (data_item || in_last);

  // Parser state; end of packet returns everything to reset values
  always_ff @(posedge clk) begin
    if (rst || (fire && in_last)) begin
      phase           <= PH_HEADER;
      field_pos       <= 2'd0;
      byte_count      <= 17'd0;
      declared_length <= 16'd0;
      command_reg     <= 8'd0;
      arg_count       <= 8'd0;
      args_seen       <= 8'd0;
      cur_type        <= 8'd0;
      remaining       <= 16'd0;
      error_code      <= V_OK;
    end else if (fire) begin
      phase           <= phase_next;
      field_pos       <= field_pos_next;
      byte_count      <= byte_count_next;
      declared_length <= declared_length_next;
      command_reg     <= command_reg_next;
      arg_count       <= arg_count_next;
      args_seen       <= args_seen_next;
      cur_type        <= cur_type_next;
      remaining       <= remaining_next;
      error_code      <= error_code_next;
    end
  end

endmodule

// ===== design/cpd_queue.sv =====
// Short FIFO of parsed work between front end and output sequencer.
// Entry type and depth from cpd_pkg.
module cpd_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  cpd_pkg::cpd_entry_t push_entry,
  input  logic                pop,
  output cpd_pkg::cpd_entry_t head,
  output logic                not_empty,
  output logic                room
);
  import cpd_pkg::*;

  cpd_entry_t          store [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign not_empty = (count != '0);
  assign room      = (count != (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head      = store[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push)
      store[wr_ptr] <= push_entry;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push)
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      if (pop)
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      case ({push, pop})
        2'b10:   count <= count + (QUEUE_AW+1)'(1);
        2'b01:   count <= count - (QUEUE_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== design/cpd_back.sv =====
// Back end: turns each queue entry into one or two output transfers.
// Data result first, then the verdict. Depends on cpd_pkg.
module cpd_back (
  input  logic                clk,
  input  logic                rst,
  input  cpd_pkg::cpd_entry_t head,
  input  logic                head_valid,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [47:0]         out_data,
  output logic [0:0]          out_user,
  output logic                out_last
);
  import cpd_pkg::*;

  // Set once the data result of a two-result entry has gone out
  logic     data_sent;
  logic     show_data;
  logic     fire;
  logic     kind;
  logic [7:0] number;
  logic [7:0] arg_kind;
  logic [7:0] payload;
  logic       arg_end;
  verdict_t   verd;

  assign show_data = head.has_data && !data_sent;
  assign out_valid = head_valid;
  assign fire      = head_valid && out_ready;
  assign pop       = fire && (!show_data || !head.has_verdict);

  // Select fields of the result on show
  always_comb begin
    if (show_data) begin
      kind     = KIND_DATA;
      number   = head.arg_number;
      arg_kind = head.arg_kind;
      payload  = head.payload;
      arg_end  = head.arg_end;
      verd     = V_OK;
      out_last = !head.has_verdict;
    end else begin
      kind     = KIND_VERDICT;
      number   = head.args_parsed;
      arg_kind = 8'd0;
      payload  = 8'd0;
      arg_end  = 1'b0;
      verd     = head.verdict;
      out_last = 1'b1;
    end
  end

  assign out_user = kind;
  assign out_data = {4'd0, verd, arg_end, payload, arg_kind, number,
                     head.arg_total, head.command};

  // Track the first half of a two-result entry
  always_ff @(posedge clk) begin
    if (rst)
      data_sent <= 1'b0;
    else if (pop)
      data_sent <= 1'b0;
    else if (fire)
      data_sent <= 1'b1;
  end

endmodule

// ===== design/command_payload_deframer.sv =====
// Channel   Dir  Width  Contents
// s_axis    in   8      packet byte; tlast on the final byte of a packet
// m_axis    out  48     tagged argument data byte or packet verdict; tuser = kind
//
// One packet byte is taken per cycle while the queue has room; a byte gives
// at most one result, the final byte of a packet up to two separate transfers.
// Parsing is done on acceptance; a 4-entry queue holds work for the output side.
// Reset (rst, synchronous) empties the queue and returns to header parsing.
// s_axis_tready drops only while the queue is full, as m_axis stalls.
// Top level; instantiates cpd_front, cpd_queue and cpd_back from cpd_pkg types.
module command_payload_deframer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // end_of_packet
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] command_code, [15:8] argument_total, [23:16] argument_number,
  // [31:24] argument_kind, [39:32] payload_byte, [40] argument_end,
  // [43:41] verdict, [47:44] zero
  output logic [47:0] m_axis_tdata,
  output logic [0:0]  m_axis_tuser,   // [0] result_kind
  output logic        m_axis_tlast    // last
);
  import cpd_pkg::*;

  cpd_entry_t push_entry;
  cpd_entry_t head;
  logic       push;
  logic       pop;
  logic       not_empty;
  logic       room;

  cpd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_data  (s_axis_tdata),
    .in_last  (s_axis_tlast),
    .room     (room),
    .push     (push),
    .entry    (push_entry)
  );

  cpd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .not_empty  (not_empty),
    .room       (room)
  );

  cpd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (not_empty),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (m_axis_tdata),
    .out_user   (m_axis_tuser),
    .out_last   (m_axis_tlast)
  );

endmodule
